/* design/text_console_cell_buffer_core_macros.svh */
// assertion macros for the console cell buffer
`ifndef TEXT_CONSOLE_CELL_BUFFER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CELL_BUFFER_CORE_MACROS_SVH

// same-cycle implication under clk and rst_n
`define TCCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under clk and rst_n
`define TCCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tccb_pkg.sv */
// shared types and constants for the console cell buffer
package tccb_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 20;

  localparam logic       KIND_PUT  = 1'b0;
  localparam logic       KIND_READ = 1'b1;

  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] BLANK     = 8'h20;
  localparam logic [2:0] TAB_STOP  = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

/* design/tccb_addr_unit.sv */
// shared address unit: rotates a screen row by the scroll offset and forms the cell address
module tccb_addr_unit import tccb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int ROW_W   = $clog2(ROWS),
  parameter int CIDX_W  = $clog2(COLUMNS),
  parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
  input  logic [ROW_W-1:0]  log_row,
  input  logic [ROW_W-1:0]  top_row,
  input  logic [CIDX_W-1:0] col_idx,
  output logic [ROW_W-1:0]  phys_row,
  output logic [ADDR_W-1:0] addr
);

  logic [ROW_W:0] row_sum;

  always_comb begin
    row_sum = {1'b0, log_row} + {1'b0, top_row};
    if (row_sum >= (ROW_W + 1)'(ROWS)) begin
      row_sum = row_sum - (ROW_W + 1)'(ROWS);
    end
    phys_row = row_sum[ROW_W-1:0];
    addr     = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col_idx);
  end

endmodule

/* design/tccb_cell_ram.sv */
// single-port screen cell memory with registered read data
module tccb_cell_ram import tccb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
  input  logic              clk,
  input  ram_ctl_t          ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  localparam int DEPTH = ROWS * COLUMNS;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/text_console_cell_buffer_core.sv */
// top level of the console cell buffer: command sequencer, cursor and scroll state
//
// A command is taken on a rising edge with start high and busy low; in_item carries
// the kind (put a byte or read one cell), the byte and the cell to read. Each command
// gives one result on out_item, shown for exactly one cycle with out_strobe high;
// the receiver cannot stall, so the result must be taken in that cycle.
// States from the accepting edge: decode, then the steps of the kind, and last done:
//   newline, carriage return, backspace at column 0: no further steps
//   backspace: one cell write
//   printable byte: a store step, which first takes a pending wrap, and a cell write
//   tab: a store step and a cell write per blank written (1 to 4 blanks), plus wraps
//   read: address, then registered data (an out-of-range read skips both)
// The first write into a row after reset or after that row was scrolled in
// first blanks the whole row, one cell a cycle through the
// single memory port. Scrolling itself is a row-offset step and costs nothing.
// Reset clears the cursor, the scroll offset and the per-row filled flags, so
// every cell reads as a space at once; there is no clearing pass. busy stays
// high from the accepting edge until the strobe cycle, which may take a new start.
`include "text_console_cell_buffer_core_macros.svh"

module text_console_cell_buffer_core import tccb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int CIDX_W = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(ROWS * COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STORE,
    S_CELL,
    S_SWEEP,
    S_RDADDR,
    S_RDDATA,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  line_r, line_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROWS-1:0]   row_valid_r, row_valid_nxt;
  logic [2:0]        rem_r, rem_nxt;
  logic              adv_r, adv_nxt;
  logic [7:0]        val_r, val_nxt;
  logic [CIDX_W-1:0] sweep_r, sweep_nxt;
  logic [7:0]        cell_r, cell_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              rd_phase;
  logic [ROW_W-1:0]  log_row;
  logic [CIDX_W-1:0] col_idx;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] addr;
  ram_ctl_t          ram_ctl;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              rd_in_range;
  logic              at_last_row;
  logic [ROW_W-1:0]  top_inc;

  assign rd_phase = (state_r == S_RDADDR) || (state_r == S_RDDATA);

  always_comb begin
    log_row = rd_phase ? ROW_W'(item_r.read_row) : line_r;
    if (state_r == S_SWEEP) begin
      col_idx = sweep_r;
    end else if (rd_phase) begin
      col_idx = CIDX_W'(item_r.read_col);
    end else begin
      col_idx = col_r[CIDX_W-1:0];
    end
  end

  tccb_addr_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ROW_W   (ROW_W),
    .CIDX_W  (CIDX_W),
    .ADDR_W  (ADDR_W)
  ) u_addr (
    .log_row  (log_row),
    .top_row  (top_r),
    .col_idx  (col_idx),
    .phys_row (phys_row),
    .addr     (addr)
  );

  tccb_cell_ram #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .addr  (addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_in_range = (32'(item_r.read_row) < ROWS) && (32'(item_r.read_col) < COLUMNS);
  assign at_last_row = (line_r == ROW_W'(ROWS - 1));
  assign top_inc     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
  assign ram_wdata   = (state_r == S_SWEEP) ? BLANK : val_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    top_nxt        = top_r;
    row_valid_nxt  = row_valid_r;
    rem_nxt        = rem_r;
    adv_nxt        = adv_r;
    val_nxt        = val_r;
    sweep_nxt      = sweep_r;
    cell_nxt       = cell_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ram_ctl        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cell_nxt = '0;
        if (item_r.kind == KIND_READ) begin
          state_nxt = rd_in_range ? S_RDADDR : S_DONE;
        end else begin
          unique case (item_r.char_code) inside
            CH_LF, CH_CR: begin
              col_nxt = '0;
              if (at_last_row) begin
                top_nxt              = top_inc;
                row_valid_nxt[top_r] = 1'b0;
              end else begin
                line_nxt = line_r + 1'b1;
              end
              state_nxt = S_DONE;
            end
            CH_BS: begin
              if (col_r != '0) begin
                col_nxt   = col_r - 1'b1;
                val_nxt   = BLANK;
                adv_nxt   = 1'b0;
                rem_nxt   = 3'd1;
                state_nxt = S_CELL;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CH_TAB: begin
              rem_nxt   = TAB_STOP - {1'b0, col_r[1:0]};
              val_nxt   = BLANK;
              adv_nxt   = 1'b1;
              state_nxt = S_STORE;
            end
            default: begin
              rem_nxt   = 3'd1;
              val_nxt   = item_r.char_code;
              adv_nxt   = 1'b1;
              state_nxt = S_STORE;
            end
          endcase
        end
      end
      S_STORE: begin
        if (col_r >= COL_W'(COLUMNS)) begin
          // deferred wrap
          col_nxt = '0;
          if (at_last_row) begin
            top_nxt              = top_inc;
            row_valid_nxt[top_r] = 1'b0;
          end else begin
            line_nxt = line_r + 1'b1;
          end
        end else begin
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        if (row_valid_r[phys_row]) begin
          ram_ctl.wr_en = 1'b1;
          if (adv_r) begin
            col_nxt = col_r + 1'b1;
          end
          rem_nxt   = rem_r - 1'b1;
          state_nxt = (rem_r == 3'd1) ? S_DONE : S_STORE;
        end else begin
          sweep_nxt = '0;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // blank a row before its first write
        ram_ctl.wr_en = 1'b1;
        sweep_nxt     = sweep_r + 1'b1;
        if (sweep_r == CIDX_W'(COLUMNS - 1)) begin
          row_valid_nxt[phys_row] = 1'b1;
          state_nxt               = S_CELL;
        end
      end
      S_RDADDR: begin
        ram_ctl.rd_en = 1'b1;
        state_nxt     = S_RDDATA;
      end
      S_RDDATA: begin
        cell_nxt  = row_valid_r[phys_row] ? ram_rdata : BLANK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_strobe_nxt          = 1'b1;
        out_item_nxt.cell_char  = cell_r;
        out_item_nxt.cursor_col = 7'(col_r);
        out_item_nxt.cursor_row = 5'(line_r);
        state_nxt               = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      line_r       <= '0;
      top_r        <= '0;
      row_valid_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      top_r        <= top_nxt;
      row_valid_r  <= row_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    adv_r      <= adv_nxt;
    val_r      <= val_nxt;
    sweep_r    <= sweep_nxt;
    cell_r     <= cell_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `TCCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `TCCB_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result shown while still busy")
  `TCCB_ASSERT_NOW(a_cell_col, state_r == S_CELL, col_r < COL_W'(COLUMNS), "cell write past last column")
  `TCCB_ASSERT_NOW(a_line_range, 1'b1, 32'(line_r) < ROWS && 32'(top_r) < ROWS, "row out of range")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench for text_console_cell_buffer_core: queued command driver, strobe monitor, screen predictor
module tb;
  import tccb_pkg::*;

  localparam int NCOL      = COLUMNS_DEF;
  localparam int NROW      = ROWS_DEF;
  localparam int MAX_CYCLE = 600000;
  localparam int TAIL_WAIT = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  in_item_t   cmd_queue[$];
  out_item_t  due_results[$];
  logic [7:0] screen[NROW][NCOL];
  int         cur_col;
  int         cur_row;
  int         send_idle_pct = 0;
  int         n_sent = 0;
  int         n_taken = 0;
  int         errors = 0;
  int         cycles = 0;
  bit         took = 1'b0;

  text_console_cell_buffer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // screen predictor
  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= NROW) begin
      for (int r = 0; r < NROW - 1; r++)
        for (int c = 0; c < NCOL; c++)
          screen[r][c] = screen[r+1][c];
      for (int c = 0; c < NCOL; c++)
        screen[NROW-1][c] = BLANK;
      cur_row = NROW - 1;
    end
  endfunction

  function automatic void store_glyph(logic [7:0] ch);
    if (cur_col >= NCOL)
      advance_line();
    screen[cur_row][cur_col] = ch;
    cur_col++;
  endfunction

  function automatic out_item_t screen_after(in_item_t it);
    out_item_t res;
    int        n;
    res = '0;
    if (it.kind == KIND_PUT) begin
      if (it.char_code == CH_LF || it.char_code == CH_CR) begin
        advance_line();
      end else if (it.char_code == CH_BS) begin
        if (cur_col > 0) begin
          cur_col--;
          screen[cur_row][cur_col] = BLANK;
        end
      end else if (it.char_code == CH_TAB) begin
        n = TAB_STOP - (cur_col % TAB_STOP);
        for (int i = 0; i < n; i++)
          store_glyph(BLANK);
      end else begin
        store_glyph(it.char_code);
      end
    end else if (it.read_row < NROW && it.read_col < NCOL) begin
      res.cell_char = screen[it.read_row][it.read_col];
    end
    res.cursor_col = cur_col[6:0];
    res.cursor_row = cur_row[4:0];
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!start || took) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= cmd_queue.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and acceptance tracking
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t unexpected result: actual %h/%0d/%0d", $time,
                   out_item.cell_char, out_item.cursor_col, out_item.cursor_row);
      end else begin
        want = due_results.pop_front();
        if (out_item.cell_char !== want.cell_char ||
            out_item.cursor_col !== want.cursor_col ||
            out_item.cursor_row !== want.cursor_row) begin
          errors++;
          if (errors <= 50)
            $display("%0t mismatch: expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     want.cell_char, want.cursor_col, want.cursor_row,
                     out_item.cell_char, out_item.cursor_col, out_item.cursor_row);
        end
      end
    end
    took = rst_n && start && !busy;
    if (took) begin
      due_results.push_back(screen_after(in_item));
      n_taken++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_put(logic [7:0] ch);
    in_item_t it;
    it.kind      = KIND_PUT;
    it.char_code = ch;
    it.read_row  = 5'($urandom_range(31));
    it.read_col  = 7'($urandom_range(127));
    cmd_queue.push_back(it);
    n_sent++;
  endtask

  task automatic push_read(int row, int col);
    in_item_t it;
    it.kind      = KIND_READ;
    it.char_code = 8'($urandom_range(255));
    it.read_row  = 5'(row);
    it.read_col  = 7'(col);
    cmd_queue.push_back(it);
    n_sent++;
  endtask

  task automatic push_random_read();
    int row;
    int col;
    row = ($urandom_range(99) < 85) ? $urandom_range(NROW - 1) : $urandom_range(31);
    col = ($urandom_range(99) < 85) ? $urandom_range(NCOL - 1) : $urandom_range(127);
    push_read(row, col);
  endtask

  function automatic logic [7:0] random_glyph();
    if ($urandom_range(99) < 80)
      return 8'($urandom_range(8'h7e, 8'h20));
    return 8'($urandom_range(255));
  endfunction

  // fill one line to a pending wrap, then hit it with a control, a glyph or a read
  task automatic push_line_run();
    int col;
    col = 0;
    push_put(CH_CR);
    while (col < NCOL) begin
      if ($urandom_range(99) < 20) begin
        col += TAB_STOP - (col % TAB_STOP);
        push_put(CH_TAB);
      end else begin
        col++;
        push_put(random_glyph());
      end
    end
    case ($urandom_range(4))
      0: push_put(CH_BS);
      1: push_put(CH_TAB);
      2: push_put(random_glyph());
      3: push_put(CH_LF);
      default: push_random_read();
    endcase
    push_random_read();
  endtask

  task automatic push_random(int count);
    int base;
    int r;
    base = n_sent;
    push_line_run();
    while (n_sent - base < count) begin
      r = $urandom_range(999);
      if (r < 15)
        push_line_run();
      else if (r < 350)
        push_random_read();
      else begin
        r = $urandom_range(99);
        if (r < 10)      push_put(CH_LF);
        else if (r < 15) push_put(CH_CR);
        else if (r < 25) push_put(CH_BS);
        else if (r < 35) push_put(CH_TAB);
        else if (r < 85) push_put(8'($urandom_range(8'h7e, 8'h20)));
        else             push_put(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_sent || due_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    for (int r = 0; r < NROW; r++)
      for (int c = 0; c < NCOL; c++)
        screen[r][c] = BLANK;
    cur_col = 0;
    cur_row = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_read(0, 0);
    push_read(NROW - 1, NCOL - 1);
    push_read(NROW, 0);
    push_read(0, NCOL);
    push_read(31, 127);
    push_put(CH_BS);
    push_put(8'h41);
    push_put(8'h00);
    push_put(8'hff);
    push_put(8'h7f);
    push_put(CH_TAB);
    push_put(8'h78);
    push_put(CH_TAB);
    push_put(CH_BS);
    push_put(CH_LF);
    push_put(CH_CR);
    push_put(8'h80);
    push_read(0, 0);
    push_read(0, 2);
    push_read(0, 3);
    push_read(0, 8);
    push_read(2, 0);
    push_read(1, 0);
    wait_drained();

    send_idle_pct = 0;
    push_random(150);
    wait_drained();
    send_idle_pct = 57;
    push_random(150);
    wait_drained();
    send_idle_pct = 0;
    push_random(150);
    wait_drained();
    send_idle_pct = 15;
    push_random(150);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && due_results.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/tccb_pkg.sv
design/tccb_addr_unit.sv
design/tccb_cell_ram.sv
design/text_console_cell_buffer_core.sv
tb/tb.sv
